>>> design/blake2b_hash_engine_assert.svh
// Assertion macros for the BLAKE2b hash engine
`ifndef BLAKE2B_HASH_ENGINE_ASSERT_SVH
`define BLAKE2B_HASH_ENGINE_ASSERT_SVH
`define B2B_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define B2B_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> design/b2b_pkg.sv
// Package with shared types, constants and functions of the BLAKE2b engine
`default_nettype none
package b2b_pkg;
  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fad682d1a, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
  localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;

  typedef logic [3:0] sidx_t;

  // sigma(round, position)
  function automatic sidx_t sigma(input logic [3:0] rnd, input logic [3:0] pos);
    logic [63:0] row;
    case (rnd)
      4'd0, 4'd10: row = 64'hfedcba9876543210;
      4'd1, 4'd11: row = 64'h357b20c16df984ae;
      4'd2:        row = 64'h491763eadf250c8b;
      4'd3:        row = 64'h8f04a562ebcd1397;
      4'd4:        row = 64'hd386cb1efa427509;
      4'd5:        row = 64'h91ef57d438b0a6c2;
      4'd6:        row = 64'hb8293670a4def15c;
      4'd7:        row = 64'ha2684f05931ce7bd;
      4'd8:        row = 64'h5a417d2c803b9ef6;
      4'd9:        row = 64'h0dc3e9bf5167482a;
      default:     row = 64'hfedcba9876543210;
    endcase
    return row[{pos, 2'b00} +: 4];
  endfunction

  typedef struct packed {
    logic load_msg;
    logic init;
    logic final_blk;
    logic g_step;
    logic half;
    logic [3:0] rnd;
    logic [2:0] gi;
    logic fold;
    logic reload;
    logic zero_tail;
  } ctrl_t;

  typedef struct packed {
    logic [4:0] word_index;
  } stat_t;
endpackage
`default_nettype wire

>>> design/b2b_stream_if.sv
// Valid/ready stream interfaces for the message, digest and configuration channels
`default_nettype none
interface b2b_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        end_of_message;
  modport source (output valid, message_word, valid_bytes, end_of_message, input ready);
  modport sink (input valid, message_word, valid_bytes, end_of_message, output ready);
endinterface

interface b2b_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        final_word;
  modport source (output valid, digest_word, final_word, input ready);
  modport sink (input valid, digest_word, final_word, output ready);
endinterface

interface b2b_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] digest_bytes;
  modport source (output valid, digest_bytes, input ready);
  modport sink (input valid, digest_bytes, output ready);
endinterface
`default_nettype wire

>>> design/b2b_datapath.sv
// Datapath: chain, message buffer, work vector, counter and one half-G unit
`default_nettype none
module b2b_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire b2b_pkg::ctrl_t ctrl_i,
  input  wire logic [63:0]    word_i,
  input  wire logic [3:0]     nb_i,
  input  wire logic [6:0]     len_i,
  input  wire logic           clear_i,
  output b2b_pkg::stat_t      stat_o,
  output logic [63:0]         chain_o [8]
);
  logic [63:0] h_q [8];
  logic [63:0] m_q [16];
  logic [63:0] v_q [16];
  logic [63:0] cnt_q;
  logic [4:0]  widx_q;
  logic [3:0]  ia, ib, ic, id;
  logic [63:0] va, vb, vc, vd, x, na, nb2, nc, nd, t1, t2;
  logic [3:0]  sel;

  always_comb begin
    case (ctrl_i.gi)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
    sel = b2b_pkg::sigma(ctrl_i.rnd, {ctrl_i.gi, ctrl_i.half});
    x  = m_q[sel];
    va = v_q[ia]; vb = v_q[ib]; vc = v_q[ic]; vd = v_q[id];
    na = va + vb + x;
    t1 = vd ^ na;
    if (!ctrl_i.half) nd = {t1[31:0], t1[63:32]};
    else              nd = {t1[15:0], t1[63:16]};
    nc = vc + nd;
    t2 = vb ^ nc;
    if (!ctrl_i.half) nb2 = {t2[23:0], t2[63:24]};
    else              nb2 = {t2[62:0], t2[63]};
  end

  assign stat_o.word_index = widx_q;
  assign chain_o = h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      widx_q <= '0;
      for (int i = 1; i < 8; i++) h_q[i] <= b2b_pkg::IV[i];
      h_q[0] <= b2b_pkg::IV[0] ^ b2b_pkg::PARAM_BASE ^ 64'd64;
    end else if (clear_i || ctrl_i.reload) begin
      cnt_q  <= '0;
      widx_q <= '0;
      for (int i = 1; i < 8; i++) h_q[i] <= b2b_pkg::IV[i];
      h_q[0] <= b2b_pkg::IV[0] ^ b2b_pkg::PARAM_BASE ^ {57'd0, len_i};
    end else begin
      if (ctrl_i.load_msg) begin
        widx_q <= widx_q + 5'd1;
        cnt_q  <= cnt_q + {60'd0, nb_i};
      end
      if (ctrl_i.init) begin
        widx_q <= '0;
      end
      if (ctrl_i.fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i + 8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_msg) begin
      m_q[widx_q[3:0]] <= word_i;
    end
    if (ctrl_i.zero_tail) begin
      for (int i = 0; i < 16; i++)
        if (5'(i) >= widx_q) m_q[i] <= '0;
    end
    if (ctrl_i.init) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      v_q[8]  <= b2b_pkg::IV[0];
      v_q[9]  <= b2b_pkg::IV[1];
      v_q[10] <= b2b_pkg::IV[2];
      v_q[11] <= b2b_pkg::IV[3];
      v_q[12] <= b2b_pkg::IV[4] ^ cnt_q;
      v_q[13] <= b2b_pkg::IV[5];
      v_q[14] <= ctrl_i.final_blk ? ~b2b_pkg::IV[6] : b2b_pkg::IV[6];
      v_q[15] <= b2b_pkg::IV[7];
    end
    if (ctrl_i.g_step) begin
      v_q[ia] <= na; v_q[ib] <= nb2; v_q[ic] <= nc; v_q[id] <= nd;
    end
  end
endmodule
`default_nettype wire

>>> design/b2b_controller.sv
// Controller: sequences loading, compression rounds and digest output
`default_nettype none
module b2b_controller (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_fire_i,
  input  wire logic           in_last_i,
  input  wire logic           in_empty_i,
  input  wire b2b_pkg::stat_t stat_i,
  input  wire logic [6:0]     len_i,
  input  wire logic           out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output logic [2:0]          out_idx_o,
  output logic                out_last_o,
  output b2b_pkg::ctrl_t      ctrl_o
);
  typedef enum logic [2:0] {S_IDLE, S_INIT, S_RUN, S_FOLD, S_OUT} state_e;
  state_e     state_q;
  logic       fin_q;
  logic [3:0] rnd_q;
  logic [3:0] step_q;
  logic [2:0] oidx_q;
  logic [2:0] nwords;
  logic       need_comp;

  assign nwords     = 3'((len_i - 7'd1) >> 3);
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_idx_o  = oidx_q;
  assign out_last_o = (oidx_q == nwords);
  assign need_comp  = stat_i.word_index[4] && !(in_last_i && in_empty_i);

  always_comb begin
    ctrl_o = '0;
    ctrl_o.rnd  = rnd_q;
    ctrl_o.gi   = step_q[3:1];
    ctrl_o.half = step_q[0];
    ctrl_o.final_blk = fin_q;
    ctrl_o.load_msg  = (state_q == S_IDLE) && in_fire_i && !need_comp &&
                       !(stat_i.word_index[4] && in_last_i && in_empty_i);
    ctrl_o.zero_tail = (state_q == S_INIT) && fin_q;
    ctrl_o.init   = (state_q == S_INIT);
    ctrl_o.g_step = (state_q == S_RUN);
    ctrl_o.fold   = (state_q == S_FOLD);
    ctrl_o.reload = (state_q == S_OUT) && out_ready_i && out_last_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q <= 1'b0;
      rnd_q <= '0; step_q <= '0; oidx_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_fire_i) begin
          if (need_comp) begin
            fin_q <= 1'b0; state_q <= S_INIT;
          end else if (in_last_i) begin
            fin_q <= 1'b1; state_q <= S_INIT;
          end
        end
        S_INIT: begin
          rnd_q <= '0; step_q <= '0; state_q <= S_RUN;
        end
        S_RUN: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            rnd_q <= rnd_q + 4'd1;
            if (rnd_q == 4'd11) state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          oidx_q <= '0;
          state_q <= fin_q ? S_OUT : S_IDLE;
        end
        S_OUT: if (out_ready_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (out_last_o) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/blake2b_hash_engine.sv
// Top level of the unkeyed BLAKE2b hash engine
// Sequence: a word that does not follow a full buffer is accepted while the engine is idle; a word
// that follows a full buffer is held through init, 192 half-G steps of one
// shared G unit and fold before it is accepted. The first digest word is
// valid once the final word is accepted and init, the half-G steps and fold are done.
// Throughput: one message word per cycle between blocks; 1 to 8 digest words, one per cycle unless dig_o.ready is low.
// Reset: chain loaded for a 64-byte digest, counter and index cleared.
`default_nettype none
`include "blake2b_hash_engine_assert.svh"
module blake2b_hash_engine (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b2b_msg_if.sink    msg_i,
  b2b_cfg_if.sink    cfg_i,
  b2b_dig_if.source  dig_o
);
  logic [6:0]     len_q, len_d, clamp;
  logic [63:0]    word_m, chain [8], w;
  logic [3:0]     nb;
  logic           in_ready, out_valid, out_last;
  logic [2:0]     oidx;
  b2b_pkg::ctrl_t ctrl;
  b2b_pkg::stat_t stat;
  logic           cfg_fire;
  logic [63:0]    msk;
  logic [63:0]    wmask;
  logic [6:0]     rem;

  assign clamp = (cfg_i.digest_bytes == 7'd0) ? 7'd1 :
                 (cfg_i.digest_bytes > 7'd64) ? 7'd64 : cfg_i.digest_bytes;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire = cfg_i.valid;
  assign len_d = cfg_fire ? clamp : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 7'd64;
    end else begin
      len_q <= len_d;
    end
  end

  assign nb = (msg_i.valid_bytes > 4'd8) ? 4'd8 : msg_i.valid_bytes;
  always_comb begin
    msk = '1;
    for (int i = 0; i < 8; i++)
      if (4'(i) >= nb) msk[i*8 +: 8] = 8'h00;
  end
  assign word_m = msg_i.message_word & msk;

  // hold a word that forces compression of a full buffer until it is loaded
  assign msg_i.ready = in_ready &&
                       !(stat.word_index[4] && !(msg_i.end_of_message && nb == 4'd0));

  b2b_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (msg_i.valid && in_ready),
    .in_last_i  (msg_i.end_of_message),
    .in_empty_i (nb == 4'd0),
    .stat_i     (stat),
    .len_i      (len_q),
    .out_ready_i(dig_o.ready),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_idx_o  (oidx),
    .out_last_o (out_last),
    .ctrl_o     (ctrl)
  );

  b2b_datapath u_dp (
    .clk_i, .rst_ni,
    .ctrl_i (ctrl),
    .word_i (word_m),
    .nb_i   (nb),
    .len_i  (len_d),
    .clear_i(cfg_fire),
    .stat_o (stat),
    .chain_o(chain)
  );

  assign rem = len_q - {1'b0, oidx, 3'b000};
  always_comb begin
    wmask = '1;
    for (int i = 0; i < 8; i++)
      if (7'(i) >= rem) wmask[i*8 +: 8] = 8'h00;
  end
  assign w = chain[oidx];
  assign dig_o.valid       = out_valid;
  assign dig_o.digest_word = w & wmask;
  assign dig_o.final_word  = out_last;

  `B2B_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, dig_o.valid, !msg_i.ready,
    "input taken while digest pending")
  `B2B_ASSERT_IMPL(a_index_range, clk_i, rst_ni, 1'b1, stat.word_index <= 5'd16,
    "buffer index out of range")
  `B2B_ASSERT_NEXT(a_reload, clk_i, rst_ni, ctrl.reload, stat.word_index == 5'd0,
    "index not cleared after digest")
endmodule
`default_nettype wire
